FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Antecedent in this cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/apl_pkg.sv
// Types and constants of the actuator position loop.
package apl_pkg;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_HOME = 2'd1;

  localparam logic [2:0] ST_MOVING   = 3'd0;
  localparam logic [2:0] ST_LIMIT    = 3'd1;
  localparam logic [2:0] ST_DEADBAND = 3'd2;
  localparam logic [2:0] ST_HOMING   = 3'd3;
  localparam logic [2:0] ST_STOPPED  = 3'd4;

  localparam logic [2:0] CFG_GAIN     = 3'd0;
  localparam logic [2:0] CFG_SPD_LIM  = 3'd1;
  localparam logic [2:0] CFG_HOME_SPD = 3'd2;
  localparam logic [2:0] CFG_CPM      = 3'd3;
  localparam logic [2:0] CFG_DEADBAND = 3'd4;
  localparam logic [2:0] CFG_BOOST    = 3'd5;
  localparam logic [2:0] CFG_FLOOR    = 3'd6;
  localparam logic [2:0] CFG_SETTLED  = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    PH_RUN,
    PH_PAUSE,
    PH_RETRACT,
    PH_SETTLE
  } phase_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_CONV,
    CS_ERR,
    CS_MAG,
    CS_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic cap;
    logic conv;
    logic err;
    logic mag;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hw/rtl/apl_in_if.sv
// Input channel: one control request per transaction.
interface apl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] goal_length;
  logic signed [23:0] encoder_count;
  logic               limit_pressed;
  logic signed [15:0] measured_speed;

  modport source (
    output valid, req_type, goal_length, encoder_count, limit_pressed, measured_speed,
    input  ready
  );
  modport sink (
    input  valid, req_type, goal_length, encoder_count, limit_pressed, measured_speed,
    output ready
  );
endinterface

FILE: hw/rtl/apl_out_if.sv
// Output channel: one velocity result per transaction.
interface apl_out_if;
  logic               valid;
  logic               ready;
  logic               velocity_valid;
  logic signed [15:0] velocity_cmd;
  logic               encoder_reset;
  logic               homing_busy;
  logic [2:0]         status;

  modport source (
    output valid, velocity_valid, velocity_cmd, encoder_reset, homing_busy, status,
    input  ready
  );
  modport sink (
    input  valid, velocity_valid, velocity_cmd, encoder_reset, homing_busy, status,
    output ready
  );
endinterface

FILE: hw/rtl/actuator_position_loop_with_homing.sv
// Top level: actuator position loop with homing sequence.
// The captured request passes the scale-goal, error and gain-multiply registers to the
// output register in four sequencer steps (scale goal, error, gain multiply, finish);
// a result still waiting on the output holds the finish.
// A new request is taken while the previous result still waits on the output channel.
// Reset (rst, synchronous): settings to defaults, loop running and not homing,
// pause count zero, sequencer idle, output channel empty.
`include "assert_macros.svh"

module actuator_position_loop_with_homing import apl_pkg::*; #(
  parameter int PAUSE_TICKS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  apl_in_if.sink                in_ch,
  apl_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: capture, scale goal, error, gain multiply, finish
  apl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath owns the settings, the homing phase and the output register
  apl_dp #(
    .PAUSE_TICKS (PAUSE_TICKS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (in_ch.req_type),
    .goal_length    (in_ch.goal_length),
    .encoder_count  (in_ch.encoder_count),
    .limit_pressed  (in_ch.limit_pressed),
    .measured_speed (in_ch.measured_speed),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .velocity_valid (out_ch.velocity_valid),
    .velocity_cmd   (out_ch.velocity_cmd),
    .encoder_reset  (out_ch.encoder_reset),
    .homing_busy    (out_ch.homing_busy),
    .status         (out_ch.status)
  );

  // a request in flight blocks further input until it reaches the finish step
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_ch.valid && in_ch.ready, !in_ch.ready)
  // the sequencer never overwrites a result that is still waiting
  `ASSERT_ALWAYS(a_fin_room, clk, rst, !cmd.fin || stat.out_free)
  // only homing results may report the sequence as still running
  `ASSERT_ALWAYS(a_busy_status, clk, rst,
                 !(out_ch.valid && out_ch.homing_busy) || out_ch.status == ST_HOMING)
  // encoder clear ends homing and carries no new command
  `ASSERT_ALWAYS(a_enc_reset, clk, rst,
                 !(out_ch.valid && out_ch.encoder_reset) ||
                 (!out_ch.homing_busy && !out_ch.velocity_valid))

endmodule

FILE: hw/rtl/apl_ctrl.sv
// Sequencer: steps one transaction through the datapath stages.
module apl_ctrl import apl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = CS_CONV;
        end
      end
      CS_CONV: begin
        cmd.conv   = 1'b1;
        state_next = CS_ERR;
      end
      CS_ERR: begin
        cmd.err    = 1'b1;
        state_next = CS_MAG;
      end
      CS_MAG: begin
        cmd.mag    = 1'b1;
        state_next = CS_FIN;
      end
      CS_FIN: begin
        // result lands in the output register; next request may enter now
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          in_ready   = 1'b1;
          state_next = in_valid ? CS_CONV : CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
    cmd.cap = in_valid && in_ready;
  end

endmodule

FILE: hw/rtl/apl_dp.sv
// Datapath: settings, goal scaling, error, gain multiply, homing phase, output register.
module apl_dp import apl_pkg::*; #(
  parameter int PAUSE_TICKS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            req_type,
  input  logic signed [31:0]    goal_length,
  input  logic signed [23:0]    encoder_count,
  input  logic                  limit_pressed,
  input  logic signed [15:0]    measured_speed,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  velocity_valid,
  output logic signed [15:0]    velocity_cmd,
  output logic                  encoder_reset,
  output logic                  homing_busy,
  output logic [2:0]            status
);

  localparam logic [7:0] PauseLim = 8'(PAUSE_TICKS);

  // settings
  logic [15:0]        gain;
  logic [14:0]        speed_limit;
  logic signed [15:0] homing_speed;
  logic [31:0]        counts_per_metre;
  logic [15:0]        deadband_counts;
  logic [15:0]        boost_error_counts;
  logic [14:0]        floor_speed;
  logic [14:0]        settled_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain               <= 16'd256;
      speed_limit        <= 15'd512;
      homing_speed       <= -16'sd128;
      counts_per_metre   <= 32'd0;
      deadband_counts    <= 16'd50;
      boost_error_counts <= 16'd5;
      floor_speed        <= 15'd26;
      settled_speed      <= 15'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN:     gain               <= cfg_data[15:0];
        CFG_SPD_LIM:  speed_limit        <= cfg_data[14:0];
        CFG_HOME_SPD: homing_speed       <= cfg_data[15:0];
        CFG_CPM:      counts_per_metre   <= cfg_data;
        CFG_DEADBAND: deadband_counts    <= cfg_data[15:0];
        CFG_BOOST:    boost_error_counts <= cfg_data[15:0];
        CFG_FLOOR:    floor_speed        <= cfg_data[14:0];
        CFG_SETTLED:  settled_speed      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic [1:0]         req_r;
  logic signed [31:0] goal_r;
  logic signed [23:0] enc_r;
  logic               limit_r;
  logic signed [15:0] meas_r;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r   <= req_type;
      goal_r  <= goal_length;
      enc_r   <= encoder_count;
      limit_r <= limit_pressed;
      meas_r  <= measured_speed;
    end
  end

  // stage 1: |goal| * counts_per_metre, upper word
  logic [31:0] gmag;
  logic [63:0] prod;
  logic [31:0] cnt_r;
  logic        gneg_r;

  assign gmag = goal_r[31] ? (32'd0 - goal_r) : goal_r;
  assign prod = {32'd0, gmag} * {32'd0, counts_per_metre};

  always_ff @(posedge clk) begin
    if (cmd.conv) begin
      cnt_r  <= prod[63:32];
      gneg_r <= goal_r[31];
    end
  end

  // stage 2: saturate to encoder range, error and its magnitude
  logic [23:0] goal_cnt;
  logic [24:0] err_c;
  logic [24:0] err_neg;
  logic [24:0] err_r;
  logic [23:0] aerr_r;

  always_comb begin
    if (gneg_r) begin
      goal_cnt = (cnt_r > 32'd8388608) ? 24'h800000 : 24'(32'd0 - cnt_r);
    end else begin
      goal_cnt = (cnt_r > 32'd8388607) ? 24'h7FFFFF : cnt_r[23:0];
    end
  end

  assign err_c   = {goal_cnt[23], goal_cnt} - {enc_r[23], enc_r};
  assign err_neg = 25'd0 - err_c;

  always_ff @(posedge clk) begin
    if (cmd.err) begin
      err_r  <= err_c;
      aerr_r <= err_c[24] ? err_neg[23:0] : err_c[23:0];
    end
  end

  // stage 3: gain * |error|
  logic [39:0] mag_r;

  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      mag_r <= {24'd0, gain} * {16'd0, aerr_r};
    end
  end

  // final: floor boost, clamp, sign, and phase update
  logic [39:0] mag_b;
  logic [14:0] mag_f;
  logic [15:0] cmd_c;
  logic        cmd_neg;
  logic [16:0] ameas;
  logic [7:0]  pc_inc;

  assign mag_b   = (aerr_r > 24'(boost_error_counts) && mag_r < 40'(floor_speed))
                   ? 40'(floor_speed) : mag_r;
  assign mag_f   = (mag_b > 40'(speed_limit)) ? speed_limit : mag_b[14:0];
  assign cmd_c   = err_r[24] ? (16'd0 - {1'b0, mag_f}) : {1'b0, mag_f};
  assign cmd_neg = err_r[24] && (mag_f != 15'd0);
  assign ameas   = meas_r[15] ? (17'd0 - {meas_r[15], meas_r}) : {1'b0, meas_r};

  phase_t      phase, phase_next;
  logic [7:0]  pause_count, pause_count_next;
  logic        vv_c, er_c;
  logic [15:0] vc_c;
  logic [2:0]  st_c;

  assign pc_inc = (pause_count != 8'hFF) ? pause_count + 8'd1 : pause_count;

  always_comb begin
    phase_next       = phase;
    pause_count_next = pause_count;
    vv_c             = 1'b0;
    vc_c             = 16'd0;
    er_c             = 1'b0;
    st_c             = ST_HOMING;
    if (req_r == REQ_HOME) begin
      phase_next       = PH_PAUSE;
      pause_count_next = 8'd0;
      vv_c             = 1'b1;
    end else if (req_r != REQ_TICK) begin
      phase_next       = PH_RUN;
      pause_count_next = 8'd0;
      vv_c             = 1'b1;
      st_c             = ST_STOPPED;
    end else begin
      case (phase)
        PH_PAUSE: begin
          pause_count_next = pc_inc;
          if (pc_inc >= PauseLim) begin
            vv_c = 1'b1;
            if (limit_r) begin
              phase_next = PH_SETTLE;
            end else begin
              phase_next = PH_RETRACT;
              vc_c       = homing_speed;
            end
          end
        end
        PH_RETRACT: begin
          if (limit_r) begin
            phase_next = PH_SETTLE;
            vv_c       = 1'b1;
          end
        end
        PH_SETTLE: begin
          if (ameas <= 17'(settled_speed)) begin
            phase_next       = PH_RUN;
            pause_count_next = 8'd0;
            er_c             = 1'b1;
          end
        end
        default: begin
          vv_c = 1'b1;
          if (aerr_r <= 24'(deadband_counts)) begin
            st_c = ST_DEADBAND;
          end else if (limit_r && cmd_neg) begin
            st_c = ST_LIMIT;
          end else begin
            st_c = ST_MOVING;
            vc_c = cmd_c;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_RUN;
      pause_count <= 8'd0;
    end else if (cmd.fin) begin
      phase       <= phase_next;
      pause_count <= pause_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      velocity_valid <= vv_c;
      velocity_cmd   <= vc_c;
      encoder_reset  <= er_c;
      homing_busy    <= (phase_next != PH_RUN);
      status         <= st_c;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

FILE: tb/sv/actuator_position_loop_with_homing_tb.sv
// Self-checking testbench for the actuator position loop with homing sequence.
module actuator_position_loop_with_homing_tb;
  import apl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Request codes the package leaves unnamed: a stop, and the spare code that
  // the block must treat as a stop as well.
  localparam logic [1:0] REQ_STOP  = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam int HOMING_PAUSE_TICKS = 10;
  // Cycles allowed after the last result before settings change or the run ends.
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 270;

  // One request transaction as the loop sees it.
  typedef struct {
    logic [1:0]         req;
    logic signed [31:0] goal;
    logic signed [23:0] enc;
    logic               limit;
    logic signed [15:0] meas;
  } loop_req_t;

  // One velocity result transaction.
  typedef struct {
    logic               velocity_valid;
    logic signed [15:0] velocity_cmd;
    logic               encoder_reset;
    logic               homing_busy;
    logic [2:0]         status;
  } loop_res_t;

  // Full register set of the loop.
  typedef struct {
    logic [15:0]        gain;
    logic [14:0]        speed_limit;
    logic signed [15:0] homing_speed;
    logic [31:0]        cpm;
    logic [15:0]        deadband;
    logic [15:0]        boost;
    logic [14:0]        floor_spd;
    logic [14:0]        settled;
  } loop_settings_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  apl_in_if  in_ch ();
  apl_out_if out_ch ();

  actuator_position_loop_with_homing #(
    .PAUSE_TICKS(HOMING_PAUSE_TICKS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the registers, kept in step with every write.
  logic [15:0]        cfg_gain;
  logic [14:0]        cfg_speed_limit;
  logic signed [15:0] cfg_home_speed;
  logic [31:0]        cfg_cpm;
  logic [15:0]        cfg_deadband;
  logic [15:0]        cfg_boost;
  logic [14:0]        cfg_floor_spd;
  logic [14:0]        cfg_settled;

  // Shadow of the homing sequencer.
  phase_t     loop_phase;
  logic [7:0] pause_ticks_seen;

  // Velocity results still owed by the block, oldest first.
  loop_res_t expected_velocity[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_requests    = 0;
  int n_results     = 0;
  int n_homing_runs = 0;
  int n_settings    = 0;
  int n_mismatches  = 0;

  function automatic void reset_predictor();
    cfg_gain         = 16'd256;
    cfg_speed_limit  = 15'd512;
    cfg_home_speed   = -16'sd128;
    cfg_cpm          = 32'd0;
    cfg_deadband     = 16'd50;
    cfg_boost        = 16'd5;
    cfg_floor_spd    = 15'd26;
    cfg_settled      = 15'd3;
    loop_phase       = PH_RUN;
    pause_ticks_seen = 8'd0;
  endfunction

  // Goal length (Q16.16 m) to encoder counts: magnitude scaled, truncated toward
  // zero, then saturated to the 24 bit encoder range.
  function automatic longint goal_to_count(input logic signed [31:0] goal,
                                           input logic [31:0] cpm);
    longint          g;
    longint unsigned gmag, c64, cnt;
    longint          res;
    g    = goal;
    gmag = (g < 0) ? -g : g;
    c64  = cpm;
    cnt  = (gmag * c64) >> 32;
    if (g < 0) res = (cnt > 64'd8388608) ? -64'sd8388608 : -longint'(cnt);
    else res = (cnt > 64'd8388607) ? 64'sd8388607 : longint'(cnt);
    return res;
  endfunction

  // Next velocity result for one accepted request; advances the shadow sequencer.
  function automatic loop_res_t predict_velocity(input loop_req_t r);
    loop_res_t res;
    longint goal_cnt, enc, err, aerr, mag, cmd, meas_mag;
    res.velocity_valid = 1'b0;
    res.velocity_cmd   = '0;
    res.encoder_reset  = 1'b0;
    res.status         = ST_HOMING;
    if (r.req == REQ_HOME) begin
      // A start while homing simply restarts the pause.
      loop_phase         = PH_PAUSE;
      pause_ticks_seen   = 8'd0;
      res.velocity_valid = 1'b1;
    end else if (r.req != REQ_TICK) begin
      loop_phase         = PH_RUN;
      pause_ticks_seen   = 8'd0;
      res.velocity_valid = 1'b1;
      res.status         = ST_STOPPED;
    end else begin
      case (loop_phase)
        PH_PAUSE: begin
          if (pause_ticks_seen < 8'd255) pause_ticks_seen++;
          if (pause_ticks_seen >= HOMING_PAUSE_TICKS) begin
            res.velocity_valid = 1'b1;
            if (r.limit) begin
              loop_phase = PH_SETTLE;
            end else begin
              loop_phase       = PH_RETRACT;
              res.velocity_cmd = cfg_home_speed;
            end
          end
        end
        PH_RETRACT: begin
          if (r.limit) begin
            loop_phase         = PH_SETTLE;
            res.velocity_valid = 1'b1;
          end
        end
        PH_SETTLE: begin
          meas_mag = r.meas;
          if (meas_mag < 0) meas_mag = -meas_mag;
          if (meas_mag <= longint'(cfg_settled)) begin
            loop_phase        = PH_RUN;
            pause_ticks_seen  = 8'd0;
            res.encoder_reset = 1'b1;
          end
        end
        default: begin
          goal_cnt = goal_to_count(r.goal, cfg_cpm);
          enc      = r.enc;
          err      = goal_cnt - enc;
          aerr     = (err < 0) ? -err : err;
          mag      = longint'(cfg_gain) * aerr;
          if (aerr > longint'(cfg_boost) && mag < longint'(cfg_floor_spd))
            mag = longint'(cfg_floor_spd);
          if (mag > longint'(cfg_speed_limit)) mag = longint'(cfg_speed_limit);
          cmd = (err < 0) ? -mag : mag;
          res.velocity_valid = 1'b1;
          if (aerr <= longint'(cfg_deadband)) begin
            res.status = ST_DEADBAND;
          end else if (r.limit && cmd < 0) begin
            res.status = ST_LIMIT;
          end else begin
            res.status       = ST_MOVING;
            res.velocity_cmd = cmd[15:0];
          end
        end
      endcase
    end
    res.homing_busy = (loop_phase != PH_RUN);
    return res;
  endfunction

  // Output side stalls at random; held low through reset.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic signed [15:0] want,
                             input logic signed [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      n_mismatches++;
    end
  endtask

  // Result checker: every output transaction against the oldest expectation.
  always @(posedge clk) begin
    loop_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_velocity.size() == 0) begin
        $display("%0t ns: result expected none actual status %0d cmd %0d", $time,
                 out_ch.status, out_ch.velocity_cmd);
        n_mismatches++;
      end else begin
        want = expected_velocity.pop_front();
        check_field("velocity_valid", 16'(want.velocity_valid),
                    16'(out_ch.velocity_valid));
        check_field("velocity_cmd", want.velocity_cmd, out_ch.velocity_cmd);
        check_field("encoder_reset", 16'(want.encoder_reset), 16'(out_ch.encoder_reset));
        check_field("homing_busy", 16'(want.homing_busy), 16'(out_ch.homing_busy));
        check_field("status", 16'(want.status), 16'(out_ch.status));
        n_results++;
      end
    end
  end

  // One request transaction. Entered just after a rising edge; leaves valid high
  // after acceptance so that a back-to-back request keeps it high.
  task automatic send_request(input logic [1:0] req, input logic signed [31:0] goal,
                              input logic signed [23:0] enc, input logic limit,
                              input logic signed [15:0] meas);
    loop_req_t r;
    r.req   = req;
    r.goal  = goal;
    r.enc   = enc;
    r.limit = limit;
    r.meas  = meas;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= req;
    in_ch.goal_length    <= goal;
    in_ch.encoder_count  <= enc;
    in_ch.limit_pressed  <= limit;
    in_ch.measured_speed <= meas;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_velocity.push_back(predict_velocity(r));
    n_requests++;
  endtask

  // Hold off the input until every owed result has come out, then let the
  // pipeline settle. Used before register writes and as back-pressure.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_velocity.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers on consecutive edges; block must be idle.
  task automatic load_settings(input loop_settings_t s);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GAIN;
    cfg_data  <= 32'(s.gain);
    @(posedge clk);
    cfg_index <= CFG_SPD_LIM;
    cfg_data  <= 32'(s.speed_limit);
    @(posedge clk);
    cfg_index <= CFG_HOME_SPD;
    cfg_data  <= 32'(s.homing_speed);
    @(posedge clk);
    cfg_index <= CFG_CPM;
    cfg_data  <= s.cpm;
    @(posedge clk);
    cfg_index <= CFG_DEADBAND;
    cfg_data  <= 32'(s.deadband);
    @(posedge clk);
    cfg_index <= CFG_BOOST;
    cfg_data  <= 32'(s.boost);
    @(posedge clk);
    cfg_index <= CFG_FLOOR;
    cfg_data  <= 32'(s.floor_spd);
    @(posedge clk);
    cfg_index <= CFG_SETTLED;
    cfg_data  <= 32'(s.settled);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_gain        = s.gain;
    cfg_speed_limit = s.speed_limit;
    cfg_home_speed  = s.homing_speed;
    cfg_cpm         = s.cpm;
    cfg_deadband    = s.deadband;
    cfg_boost       = s.boost;
    cfg_floor_spd   = s.floor_spd;
    cfg_settled     = s.settled;
    n_settings++;
  endtask

  // Mostly modest values so the loop spends time outside saturation and deadband.
  function automatic loop_settings_t random_settings();
    loop_settings_t s;
    s.gain = ($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
    s.speed_limit = ($urandom_range(2) == 0) ? 15'($urandom)
                                             : 15'($urandom_range(64, 2048));
    s.homing_speed = 16'(-int'($urandom_range(0, 32768)));
    s.cpm = ($urandom_range(2) == 0) ? $urandom : $urandom_range(1 << 20, 1 << 28);
    s.deadband = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
    s.boost = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
    s.floor_spd = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 300));
    s.settled = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 200));
    return s;
  endfunction

  // Control tick: goal of any size; encoder usually placed near the converted
  // goal so that deadband, boost and clamp edges all get hit.
  task automatic send_random_tick();
    logic signed [31:0] goal;
    logic signed [23:0] enc;
    logic signed [15:0] meas;
    longint span, pos;
    case ($urandom_range(3))
      0: goal = $urandom;
      3: begin
        case ($urandom_range(3))
          0: goal = 32'sh7FFF_FFFF;
          1: goal = 32'sh8000_0000;
          2: goal = 32'sh0000_0000;
          default: goal = 32'shFFFF_FFFF;
        endcase
      end
      default: begin
        goal = $urandom >> $urandom_range(1, 31);
        if ($urandom_range(1)) goal = -goal;
      end
    endcase
    if ($urandom_range(4) == 0) begin
      enc = 24'($urandom);
    end else begin
      span = longint'(cfg_deadband) + longint'(cfg_boost) + 300;
      pos  = goal_to_count(goal, cfg_cpm) + longint'($urandom_range(0, 2 * span)) - span;
      if (pos > 8388607) pos = 8388607;
      if (pos < -8388608) pos = -8388608;
      enc = pos[23:0];
    end
    meas = $urandom_range(1) ? 16'($urandom) : 16'(int'($urandom_range(0, 20)) - 10);
    send_request(REQ_TICK, goal, enc, ($urandom_range(2) == 0), meas);
  endtask

  // A homing run steered by the shadow sequencer: ticks carry random ignored
  // content, the limit and speed are chosen to move the sequence on, and now
  // and then a stop, the spare code or a restart breaks in.
  task automatic run_homing_sequence();
    int steps;
    logic limit;
    logic signed [15:0] meas;
    logic [1:0] code;
    send_request(REQ_HOME, $urandom, 24'($urandom), 1'($urandom_range(1)), 16'($urandom));
    n_homing_runs++;
    steps = 0;
    while (loop_phase != PH_RUN && steps < 40) begin
      steps++;
      if ($urandom_range(59) == 0) begin
        case ($urandom_range(2))
          0: code = REQ_STOP;
          1: code = REQ_SPARE;
          default: code = REQ_HOME;
        endcase
        send_request(code, $urandom, 24'($urandom), 1'($urandom_range(1)), 16'($urandom));
      end else begin
        case (loop_phase)
          PH_PAUSE: begin
            limit = ($urandom_range(3) == 0);
          end
          PH_RETRACT: begin
            limit = ($urandom_range(2) == 0);
          end
          default: begin
            limit = 1'($urandom_range(1));
          end
        endcase
        if (loop_phase == PH_SETTLE && $urandom_range(1)) begin
          meas = 16'(int'($urandom_range(0, cfg_settled)));
          if ($urandom_range(1)) meas = -meas;
        end else begin
          meas = 16'($urandom);
        end
        send_request(REQ_TICK, $urandom, 24'($urandom), limit, meas);
      end
    end
  endtask

  // Random mix: homing runs carry most transactions, plain ticks the rest,
  // with stray stops and the odd full drain of the pipeline.
  task automatic run_mixed_traffic(input int n_items);
    int start;
    int pick;
    start = n_requests;
    while (n_requests - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        run_homing_sequence();
      end else if (pick < 94) begin
        send_random_tick();
      end else if (pick < 98) begin
        send_request($urandom_range(1) ? REQ_STOP : REQ_SPARE, $urandom, 24'($urandom),
                     1'($urandom_range(1)), 16'($urandom));
      end else begin
        wait_drained();
      end
    end
  endtask

  // Small gain so boost, clamp, deadband and truncation are all reachable;
  // 1000 counts per metre.
  localparam loop_settings_t DIRECTED_SETTINGS = '{
    gain: 16'd4, speed_limit: 15'd512, homing_speed: -16'sd128, cpm: 32'd65536000,
    deadband: 16'd2, boost: 16'd5, floor_spd: 15'd26, settled: 15'd3
  };

  localparam loop_settings_t MAX_SETTINGS = '{
    gain: 16'hFFFF, speed_limit: 15'h7FFF, homing_speed: -16'sd32768,
    cpm: 32'hFFFF_FFFF, deadband: 16'hFFFF, boost: 16'hFFFF, floor_spd: 15'h7FFF,
    settled: 15'h7FFF
  };

  localparam loop_settings_t ZERO_SETTINGS = '{
    gain: 16'd0, speed_limit: 15'd0, homing_speed: 16'sd0, cpm: 32'd0,
    deadband: 16'd0, boost: 16'd0, floor_spd: 15'd0, settled: 15'd0
  };

  // Control law edge cases one transaction at a time.
  task automatic test_directed_control();
    wait_drained();
    load_settings(DIRECTED_SETTINGS);
    // goal and encoder at opposite extremes: saturation both ways, clamp both signs
    send_request(REQ_TICK, 32'sh7FFF_FFFF, 24'sh80_0000, 1'b0, 16'sh0000);
    send_request(REQ_TICK, 32'sh8000_0000, 24'sh7F_FFFF, 1'b0, 16'sh7FFF);
    // error right at the deadband edge
    send_request(REQ_TICK, 32'sd0, 24'sd2, 1'b0, 16'sh8000);
    // just outside the deadband but below the boost threshold
    send_request(REQ_TICK, 32'sd0, -24'sd3, 1'b0, 16'sd0);
    // above the boost threshold with a tiny product: floor speed enforced
    send_request(REQ_TICK, 32'sd0, -24'sd6, 1'b1, 16'sd0);
    // retracting against the pressed limit, then extending against it
    send_request(REQ_TICK, 32'sd0, 24'sd200, 1'b1, 16'sd0);
    send_request(REQ_TICK, 32'sd0, -24'sd200, 1'b1, 16'sd0);
    // a fraction of a count below zero truncates toward zero
    send_request(REQ_TICK, -32'sd65, -24'sd4, 1'b0, 16'sd0);
    send_request(REQ_STOP, 32'sd65536, 24'sd0, 1'b0, 16'sd0);
    send_request(REQ_SPARE, 32'sd65536, 24'sd0, 1'b1, 16'sd0);
  endtask

  // One clean homing run, then a restart and an abort.
  task automatic test_directed_homing();
    int k;
    send_request(REQ_HOME, 32'sd0, 24'sd0, 1'b0, 16'sd0);
    // pause ticks: goal, encoder and limit are ignored until the last one
    for (k = 1; k < HOMING_PAUSE_TICKS; k++)
      send_request(REQ_TICK, $urandom, 24'($urandom), k[0], 16'($urandom));
    send_request(REQ_TICK, 32'sd0, 24'sd0, 1'b0, 16'sd0);
    send_request(REQ_TICK, 32'sd0, 24'sd0, 1'b0, 16'sd0);
    send_request(REQ_TICK, 32'sd0, 24'sd0, 1'b1, 16'sd100);
    // settling: still moving, then exactly at the settled speed (negative side)
    send_request(REQ_TICK, 32'sd0, 24'sd0, 1'b1, 16'sd100);
    send_request(REQ_TICK, 32'sd0, 24'sd0, 1'b1, -16'sd3);
    send_request(REQ_HOME, 32'sd0, 24'sd0, 1'b0, 16'sd0);
    send_request(REQ_TICK, 32'sd0, 24'sd0, 1'b0, 16'sd0);
    send_request(REQ_HOME, 32'sd0, 24'sd0, 1'b0, 16'sd0);
    send_request(REQ_STOP, 32'sd0, 24'sd0, 1'b0, 16'sd0);
    n_homing_runs += 2;
  endtask

  task automatic test_typical_settings();
    wait_drained();
    load_settings('{gain: 16'd256, speed_limit: 15'd512, homing_speed: -16'sd128,
                    cpm: 32'd65536000, deadband: 16'd50, boost: 16'd5,
                    floor_spd: 15'd26, settled: 15'd3});
    run_mixed_traffic(ITEMS_PER_PHASE);
  endtask

  task automatic test_extreme_settings();
    wait_drained();
    load_settings(MAX_SETTINGS);
    run_mixed_traffic(ITEMS_PER_PHASE);
    wait_drained();
    load_settings(ZERO_SETTINGS);
    run_mixed_traffic(ITEMS_PER_PHASE);
  endtask

  task automatic test_random_settings(input int n_sets);
    int k;
    for (k = 0; k < n_sets; k++) begin
      wait_drained();
      load_settings(random_settings());
      run_mixed_traffic(ITEMS_PER_PHASE);
    end
  endtask

  initial begin
    // every input known from time zero; output ready is held by its own process
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_GAIN;
    cfg_data             <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.req_type       <= REQ_TICK;
    in_ch.goal_length    <= '0;
    in_ch.encoder_count  <= '0;
    in_ch.limit_pressed  <= 1'b0;
    in_ch.measured_speed <= '0;
    reset_predictor();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    send_idle_pct = 19;
    recv_idle_pct = 50;
    test_directed_control();
    test_directed_homing();
    test_typical_settings();
    test_extreme_settings();

    // roles swapped
    send_idle_pct = 50;
    recv_idle_pct = 19;
    test_random_settings(2);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_settings(2);

    wait_drained();
    $display("Run covered %0d request transactions, %0d homing runs, %0d register sets;",
             n_requests, n_homing_runs, n_settings);
    $display("%0d result transactions checked field by field.", n_results);
    if (n_mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: actuator_position_loop_with_homing.f
+incdir+hw/rtl
hw/rtl/apl_pkg.sv
hw/rtl/apl_in_if.sv
hw/rtl/apl_out_if.sv
hw/rtl/apl_ctrl.sv
hw/rtl/apl_dp.sv
hw/rtl/actuator_position_loop_with_homing.sv
tb/sv/actuator_position_loop_with_homing_tb.sv
